// ----- src/assert_macros.svh -----
// Assertion macros shared by the timestamp converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define MTSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MTSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define MTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MTSC_ASSERT(lbl, clk, rst, prop, msg)
`define MTSC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define MTSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/mtsc_pkg.sv -----
// Types and constants of the counter to nanosecond timestamp converter.
`default_nettype none

package mtsc_pkg;

  localparam logic [63:0] ONE_SECOND_NS = 64'd1000000000;
  localparam logic [31:0] NS_PER_MS     = 32'd1000000;

  // Tick divider runs two quotient bits per cycle
  localparam logic [5:0] DIV_TICKS_STEPS = 6'd16;  // 32-bit quotient
  // Millisecond divide: four 16-bit digits, an estimate step and a commit step each
  localparam logic [5:0] DIV_MS_STEPS    = 6'd8;

  // 1000000 = 2^6 * 15625; each digit is divided by 15625 with a reciprocal
  localparam logic [13:0] MS_ODD_DIVISOR = 14'd15625;
  localparam logic [30:0] MS_RECIP       = 31'd1125899907;  // ceil(2^44 / 15625)

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_SCALE,
    S_DIV_TICKS,
    S_SINCE,
    S_PICK,
    S_DIV_MS
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch request fields
    logic clamp;      // elapsed ticks, clamped to the interval
    logic scale;      // multiply and load the tick divider
    logic div_run;    // advance the divider
    logic delta_take; // keep the tick quotient as delta
    logic since;      // distance of last timestamp from base
    logic pick;       // choose result, update state, load ms divider
    logic emit;       // write the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ticks_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- src/mtsc_if.sv -----
// Channel interfaces: request, result and configuration write.
`default_nettype none

interface mtsc_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] counter_now;
  logic [63:0] base_counter;
  logic [63:0] base_time_ns;
  logic [31:0] interval_ticks;

  modport source (output valid, counter_now, base_counter, base_time_ns, interval_ticks,
                  input ready);
  modport sink (input valid, counter_now, base_counter, base_time_ns, interval_ticks,
                output ready);
endinterface

interface mtsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] time_ns;
  logic [44:0] time_ms;
  logic        stepped;
  logic [31:0] step_total;

  modport source (output valid, time_ns, time_ms, stepped, step_total, input ready);
  modport sink (input valid, time_ns, time_ms, stepped, step_total, output ready);
endinterface

interface mtsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_nanoseconds;

  modport source (output valid, interval_nanoseconds, input ready);
  modport sink (input valid, interval_nanoseconds, output ready);
endinterface

`default_nettype wire

// ----- src/mtsc_ctrl.sv -----
// Sequencer of the timestamp converter: walks one request through the datapath.
`default_nettype none

module mtsc_ctrl
  import mtsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = sts.ticks_zero ? S_SINCE : S_DIV_TICKS;
      end
      S_DIV_TICKS: begin
        if (sts.div_done) begin
          cmd.delta_take = 1'b1;
          state_next     = S_SINCE;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      S_SINCE: begin
        cmd.since  = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_DIV_MS;
      end
      S_DIV_MS: begin
        if (!sts.div_done) begin
          cmd.div_run = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/mtsc_dp.sv -----
// Datapath: clamp, scale, radix-4 tick divider, reciprocal ms divide, step and output register.
`default_nettype none

module mtsc_dp
  import mtsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic [63:0] counter_now,
  input  logic [63:0] base_counter,
  input  logic [63:0] base_time_ns,
  input  logic [31:0] interval_ticks,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] time_ns,
  output logic [44:0] time_ms,
  output logic        stepped,
  output logic [31:0] step_total
);

  logic [63:0] now_r;
  logic [63:0] base_r;
  logic [63:0] base_ns_r;
  logic [31:0] ticks_r;
  logic [31:0] interval_ns;
  logic [31:0] elapsed;
  logic [31:0] delta;
  logic [63:0] since_base;
  logic [63:0] last_ts;
  logic [31:0] step_count;
  logic        step;

  // Divider: remainder, dividend/quotient shift register, step counter, mode
  logic [31:0] div_rem;
  logic [63:0] div_dq;
  logic [5:0]  div_cnt;
  logic        div_ms;

  // Millisecond digit divide: running remainder and digit estimate
  logic [13:0] ms_rem;
  logic [15:0] ms_q;

  logic [63:0] diff;
  logic [63:0] product;
  logic        stale;
  logic [63:0] result;
  logic [31:0] divisor;
  logic [32:0] rem_a;
  logic        ge_a;
  logic [31:0] rem_a_s;
  logic [32:0] rem_b;
  logic        ge_b;
  logic [31:0] rem_b_s;
  logic [29:0] ms_v;
  logic [60:0] ms_prod;
  logic [29:0] ms_left;

  // Clamp and scale
  assign diff    = now_r - base_r;
  assign product = {32'd0, elapsed} * {32'd0, interval_ns};

  // Monotonic choice: step past the last timestamp when it is recent and not behind
  assign stale  = (since_base > ONE_SECOND_NS) || (since_base[31:0] < delta);
  assign result = stale ? (base_ns_r + {32'd0, delta}) : (last_ts + 64'd1);

  // Two restoring divide steps per cycle
  assign divisor = ticks_r;
  assign rem_a   = {div_rem, div_dq[63]};
  assign ge_a    = rem_a >= {1'b0, divisor};
  assign rem_a_s = ge_a ? 32'(rem_a - {1'b0, divisor}) : rem_a[31:0];
  assign rem_b   = {rem_a_s, div_dq[62]};
  assign ge_b    = rem_b >= {1'b0, divisor};
  assign rem_b_s = ge_b ? 32'(rem_b - {1'b0, divisor}) : rem_b[31:0];

  // Millisecond digit: remainder and next 16 bits, quotient by reciprocal (exact below 2^30)
  assign ms_v    = {ms_rem, div_dq[63:48]};
  assign ms_prod = {31'd0, ms_v} * {30'd0, MS_RECIP};
  assign ms_left = ms_v - ({14'd0, ms_q} * {16'd0, MS_ODD_DIVISOR});

  assign sts.ticks_zero = (ticks_r == 32'd0);
  assign sts.div_done   = (div_cnt == 6'd0);
  assign sts.out_free   = !out_valid || out_ready;

  // Request capture and intermediate values
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r     <= counter_now;
      base_r    <= base_counter;
      base_ns_r <= base_time_ns;
      ticks_r   <= interval_ticks;
    end
    if (cmd.clamp) begin
      elapsed <= (diff > {32'd0, ticks_r}) ? ticks_r : diff[31:0];
    end
    if (cmd.scale && sts.ticks_zero) begin
      delta <= 32'd0;
    end else if (cmd.delta_take) begin
      delta <= div_dq[31:0];
    end
    if (cmd.since) begin
      since_base <= last_ts - base_ns_r;
    end
    if (cmd.pick) begin
      step <= !stale;
    end
  end

  // Tick divider and millisecond digit divide share the shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 6'd0;
    end else if (cmd.scale && !sts.ticks_zero) begin
      div_rem <= product[63:32];
      div_dq  <= {product[31:0], 32'd0};
      div_cnt <= DIV_TICKS_STEPS;
      div_ms  <= 1'b0;
    end else if (cmd.pick) begin
      // drop the factor 2^6 of one million up front
      div_dq  <= {6'd0, result[63:6]};
      ms_rem  <= 14'd0;
      div_cnt <= DIV_MS_STEPS;
      div_ms  <= 1'b1;
    end else if (cmd.div_run && div_ms) begin
      if (!div_cnt[0]) begin
        ms_q <= ms_prod[59:44];
      end else begin
        ms_rem <= ms_left[13:0];
        div_dq <= {div_dq[47:0], ms_q};
      end
      div_cnt <= div_cnt - 6'd1;
    end else if (cmd.div_run) begin
      div_rem <= rem_b_s;
      div_dq  <= {div_dq[61:0], ge_a, ge_b};
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // Persistent state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ts     <= 64'd0;
      step_count  <= 32'd0;
      interval_ns <= 32'd1;
    end else begin
      if (cfg_valid) begin
        interval_ns <= cfg_data;
      end
      if (cmd.pick) begin
        last_ts <= result;
        if (!stale) begin
          step_count <= step_count + 32'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      time_ns    <= last_ts;
      time_ms    <= div_dq[44:0];
      stepped    <= step;
      step_total <= step_count;
    end
  end

endmodule

`default_nettype wire

// ----- src/monotonic_tsc_to_nanosecond_clock_core.sv -----
// Top level of the cycle counter to monotonic nanosecond timestamp converter.
//
//  channel | modport | transfer carries
//  --------+---------+--------------------------------------------------------
//  req     | sink    | counter_now, base_counter, base_time_ns, interval_ticks
//  rsp     | source  | time_ns, time_ms, stepped, step_total
//  cfg     | sink    | interval_nanoseconds (always ready)
//
//  One request at a time. When interval_ticks is zero the tick divider is
//  skipped; otherwise it takes two quotient bits per cycle and the quotient
//  is then taken as the delta. The millisecond value is formed by reciprocal
//  digit steps, an estimate and a commit per digit, then the output register
//  is written. The next request can be taken the cycle after that write.
//  A stalled result holds the sequencer at its last step until rsp drains.
//  Synchronous reset clears the last timestamp, the step count and the
//  interval length (to 1 ns).
`default_nettype none

`include "assert_macros.svh"

module monotonic_tsc_to_nanosecond_clock_core
  import mtsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mtsc_req_if.sink   req,
  mtsc_rsp_if.source rsp,
  mtsc_cfg_if.sink   cfg
);

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  // Sequencer
  mtsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  mtsc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .counter_now    (req.counter_now),
    .base_counter   (req.base_counter),
    .base_time_ns   (req.base_time_ns),
    .interval_ticks (req.interval_ticks),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.interval_nanoseconds),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .time_ns        (rsp.time_ns),
    .time_ms        (rsp.time_ms),
    .stepped        (rsp.stepped),
    .step_total     (rsp.step_total)
  );

  // Checks
  `MTSC_ASSERT_IMPL(a_no_accept_while_dividing, clk, rst, in_ready, !cmd.div_run, "busy accept")
  `MTSC_ASSERT_IMPL(a_emit_needs_free_slot, clk, rst, cmd.emit, sts.out_free, "result overwritten")
  `MTSC_ASSERT_NEXT(a_emit_shows_result, clk, rst, cmd.emit, rsp.valid, "emitted result not shown")
  `MTSC_ASSERT_IMPL(a_delta_after_divide, clk, rst, cmd.delta_take, sts.div_done, "early delta")

endmodule

`default_nettype wire

// ----- verif/monotonic_tsc_to_nanosecond_clock_core_tb.sv -----
// Testbench for the cycle counter to monotonic nanosecond timestamp converter.
`default_nettype none

module monotonic_tsc_to_nanosecond_clock_core_tb;
  import mtsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP64 = 64'h8000_0000_0000_0000;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned DIR_COUNT       = 18;

  // One timestamp read request
  typedef struct packed {
    logic [63:0] counter_now;
    logic [63:0] base_counter;
    logic [63:0] base_time_ns;
    logic [31:0] interval_ticks;
  } read_req_t;

  // One timestamp result
  typedef struct packed {
    logic [63:0] time_ns;
    logic [44:0] time_ms;
    logic        stepped;
    logic [31:0] step_total;
  } stamp_t;

  // Directed stimulus row; below_last makes base_time_ns an offset under the last stamp
  typedef struct packed {
    logic        set_cfg;
    logic [31:0] cfg_value;
    logic        below_last;
    read_req_t   rd;
    logic        known;
    stamp_t      stamp;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  mtsc_req_if req_ch ();
  mtsc_rsp_if rsp_ch ();
  mtsc_cfg_if cfg_ch ();

  monotonic_tsc_to_nanosecond_clock_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Predicted state of the converter
  logic [63:0] last_ns     = '0;
  logic [31:0] step_count  = '0;
  logic [31:0] interval_ns = 32'd1;

  stamp_t      pending_stamps[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;

  // Directed rows: extremes, wrap cases, the one-second window and zero scale factors
  row_t dir_rows [DIR_COUNT] = '{
    // reset state: zero ticks and a last stamp at base steps to 1 ns
    '{1'b0, 32'd0, 1'b0, '{64'd0, 64'd0, 64'd0, 32'd0},
      1'b1, '{64'd1, 45'd0, 1'b1, 32'd1}},
    // counter behind base with full ticks, base time at the top
    '{1'b0, 32'd0, 1'b0, '{64'd0, 64'd1, ALL64, ALL32},
      1'b1, '{64'd2, 45'd0, 1'b1, 32'd2}},
    // stale last stamp, base time at the sign bit
    '{1'b0, 32'd0, 1'b0, '{64'd0, 64'd0, TOP64, 32'd0},
      1'b1, '{TOP64, 45'd9223372036854, 1'b0, 32'd2}},
    // largest timestamp and largest millisecond value
    '{1'b0, 32'd0, 1'b0, '{64'd0, 64'd0, ALL64, 32'd0},
      1'b1, '{ALL64, 45'd18446744073709, 1'b0, 32'd2}},
    // largest interval: base time plus delta wraps
    '{1'b1, ALL32, 1'b0, '{ALL64, 64'd0, ALL64, ALL32}, 1'b0, '0},
    // counter behind base clamps to a full interval
    '{1'b0, 32'd0, 1'b0, '{64'd5, 64'd10, 64'd0, 32'd1000}, 1'b0, '0},
    // base exactly at the last stamp
    '{1'b0, 32'd0, 1'b1, '{64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
    // last stamp exactly one second past base
    '{1'b0, 32'd0, 1'b1, '{64'd0, 64'd0, 64'd1000000000, 32'd0}, 1'b0, '0},
    // one nanosecond beyond the window
    '{1'b0, 32'd0, 1'b1, '{64'd0, 64'd0, 64'd1000000001, 32'd0}, 1'b0, '0},
    // delta overtakes the last stamp
    '{1'b0, 32'd0, 1'b1, '{64'd1010, 64'd1000, 64'd500, 32'd1000}, 1'b0, '0},
    // no elapsed ticks inside the window
    '{1'b0, 32'd0, 1'b1, '{64'd1000, 64'd1000, 64'd500, 32'd1000}, 1'b0, '0},
    // single tick interval
    '{1'b0, 32'd0, 1'b0, '{64'd8, 64'd7, 64'd123456789, 32'd1}, 1'b0, '0},
    // truncating divide, delta just under and then just past the last stamp
    '{1'b1, 32'd1000, 1'b1, '{64'd2, 64'd0, 64'd700, 32'd3}, 1'b0, '0},
    '{1'b0, 32'd0, 1'b1, '{64'd2, 64'd0, 64'd600, 32'd3}, 1'b0, '0},
    // elapsed one below a large interval
    '{1'b0, 32'd0, 1'b1, '{64'h7FFF_FFFF, 64'd0, 64'd100, 32'h8000_0000}, 1'b0, '0},
    // zero interval length gives zero delta
    '{1'b1, 32'd0, 1'b1, '{ALL64, 64'd0, 64'd2000000000, ALL32}, 1'b0, '0},
    '{1'b0, 32'd0, 1'b1, '{ALL64, 64'd0, 64'd0, ALL32}, 1'b0, '0},
    // back to the reset interval, counter at the top
    '{1'b1, 32'd1, 1'b0, '{ALL64, ALL64, 64'd0, ALL32}, 1'b0, '0}
  };

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  // Next timestamp and state update for one accepted read
  function automatic stamp_t predict_stamp(input read_req_t rd);
    logic [63:0] elapsed;
    logic [63:0] product;
    logic [63:0] quotient;
    logic [63:0] since;
    logic [31:0] delta;
    stamp_t      s;
    elapsed = rd.counter_now - rd.base_counter;
    delta   = '0;
    if (rd.interval_ticks != '0) begin
      if (elapsed > {32'd0, rd.interval_ticks}) begin
        elapsed = {32'd0, rd.interval_ticks};
      end
      product  = {32'd0, elapsed[31:0]} * {32'd0, interval_ns};
      quotient = product / {32'd0, rd.interval_ticks};
      delta    = quotient[31:0];
    end
    // last stamp inside the one-second window and not behind the candidate
    since = last_ns - rd.base_time_ns;
    if (since > ONE_SECOND_NS || since[31:0] < delta) begin
      s.time_ns = rd.base_time_ns + {32'd0, delta};
      s.stepped = 1'b0;
    end else begin
      s.time_ns  = last_ns + 64'd1;
      s.stepped  = 1'b1;
      step_count = step_count + 32'd1;
    end
    last_ns      = s.time_ns;
    quotient     = s.time_ns / {32'd0, NS_PER_MS};
    s.time_ms    = quotient[44:0];
    s.step_total = step_count;
    return s;
  endfunction

  // Random read, mostly near the last stamp so the window logic is exercised
  function automatic read_req_t random_read();
    read_req_t   rd;
    logic [63:0] span;
    case ($urandom_range(9))
      0: rd.interval_ticks = '0;
      1: rd.interval_ticks = ALL32;
      2: rd.interval_ticks = 32'd1;
      3, 4: rd.interval_ticks = $urandom;
      default: rd.interval_ticks = $urandom_range(2, 100000);
    endcase
    rd.base_counter = wide_random();
    case ($urandom_range(9))
      0, 1: rd.counter_now = wide_random();
      2: rd.counter_now = rd.base_counter - 64'($urandom_range(1, 1000));
      default: begin
        span = 64'($urandom_range(0, rd.interval_ticks));
        if ($urandom_range(3) == 0) begin
          span = span + 64'($urandom_range(0, rd.interval_ticks));
        end
        rd.counter_now = rd.base_counter + span;
      end
    endcase
    case ($urandom_range(9))
      0, 1: rd.base_time_ns = wide_random();
      2: begin
        case ($urandom_range(3))
          0: rd.base_time_ns = '0;
          1: rd.base_time_ns = ALL64;
          2: rd.base_time_ns = TOP64;
          default: rd.base_time_ns = last_ns - ONE_SECOND_NS;
        endcase
      end
      3: rd.base_time_ns = last_ns + 64'($urandom_range(1, 100000));
      default: rd.base_time_ns = last_ns - 64'($urandom_range(0, 1100000000));
    endcase
    return rd;
  endfunction

  // Offer one read, wait for its transfer, then queue what it should return
  task automatic issue_read(input read_req_t rd, input logic known, input stamp_t typed);
    stamp_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.counter_now    <= rd.counter_now;
    req_ch.base_counter   <= rd.base_counter;
    req_ch.base_time_ns   <= rd.base_time_ns;
    req_ch.interval_ticks <= rd.interval_ticks;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    s = predict_stamp(rd);
    pending_stamps.push_back(known ? typed : s);
  endtask

  // Stop offering reads until every queued stamp has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  task automatic write_interval(input logic [31:0] value);
    cfg_ch.valid                <= 1'b1;
    cfg_ch.interval_nanoseconds <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    interval_ns = value;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus
  initial begin : stimulus
    read_req_t   rd;
    logic [31:0] next_interval;
    rst                         <= 1'b1;
    req_ch.valid                <= 1'b0;
    req_ch.counter_now          <= '0;
    req_ch.base_counter         <= '0;
    req_ch.base_time_ns         <= '0;
    req_ch.interval_ticks       <= '0;
    cfg_ch.valid                <= 1'b0;
    cfg_ch.interval_nanoseconds <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) begin
        drain_results();
        write_interval(dir_rows[i].cfg_value);
      end
      rd = dir_rows[i].rd;
      if (dir_rows[i].below_last) begin
        rd.base_time_ns = last_ns - rd.base_time_ns;
      end
      issue_read(rd, dir_rows[i].known, dir_rows[i].stamp);
    end

    // random phases, each setting an interval length and an idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: next_interval = NS_PER_MS;
        1: next_interval = ALL32;
        2: next_interval = $urandom;
        3: next_interval = 32'd1;
        4: next_interval = '0;
        default: next_interval = $urandom_range(1, 65535);
      endcase
      write_interval(next_interval);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_asked   <= hold_asked + 1;
        end
        1: begin
          send_idle_pct = 70;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 70;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct     = 21;
        end
      endcase
      repeat (ITEMS_PER_PHASE) issue_read(random_read(), 1'b0, '0);
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side ready: random stalls, plus a long hold-off when asked
  initial begin : result_ready
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = hold_done + 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest queued stamp
  always @(posedge clk) begin
    stamp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_stamps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual time_ns %h stepped %b",
                 $time, rsp_ch.time_ns, rsp_ch.stepped);
        mismatches++;
      end else begin
        want = pending_stamps.pop_front();
        check_field("time_ns", want.time_ns, rsp_ch.time_ns);
        check_field("time_ms", {19'd0, want.time_ms}, {19'd0, rsp_ch.time_ms});
        check_field("stepped", {63'd0, want.stepped}, {63'd0, rsp_ch.stepped});
        check_field("step_total", {32'd0, want.step_total}, {32'd0, rsp_ch.step_total});
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/mtsc_pkg.sv
src/mtsc_if.sv
src/mtsc_ctrl.sv
src/mtsc_dp.sv
src/monotonic_tsc_to_nanosecond_clock_core.sv
verif/monotonic_tsc_to_nanosecond_clock_core_tb.sv
